### rtl/core/rdct_pkg.sv
// Package for the reload down-counter timer.
// Holds the item kinds, register indexes, item and result types and fixed constants.
// No dependencies; used by rdct_core and reload_down_counter_timer.
package rdct_pkg;

  // Kind of an input item.
  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_READ       = 2'd1,
    KIND_WRITE      = 2'd2,
    KIND_EXC_RETURN = 2'd3
  } kind_e;

  // Word register index, taken from address bits 3:2.
  typedef enum logic [1:0] {
    REG_CTRL    = 2'd0,
    REG_RELOAD  = 2'd1,
    REG_CURRENT = 2'd2,
    REG_CALIB   = 2'd3
  } reg_e;

  localparam int unsigned ADDR_BITS  = 8;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned EXC_BITS   = 6;
  localparam int unsigned CALIB_BITS = 24;

  // Value of the reload and current registers after reset.
  localparam logic [31:0] RESET_COUNT = 32'h0000_aaaa;
  // Exception number whose return drops the interrupt request.
  localparam logic [EXC_BITS-1:0] TICK_EXCEPTION = 6'd15;

  // One input item.
  typedef struct packed {
    kind_e                 kind;
    logic [ADDR_BITS-1:0]  address;
    logic [DATA_BITS-1:0]  write_data;
    logic [EXC_BITS-1:0]   exception_number;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 irq;
    logic                 address_error;
  } result_t;

endpackage

### rtl/core/rdct_core.sv
// Timer state and register file of the reload down-counter timer.
// Executes one item per cycle while exec_i is high and updates the state; the result is combinational.
// Depends on rdct_pkg.
module rdct_core #(
  parameter int unsigned COUNTER_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             exec_i,
  input  rdct_pkg::item_t                  item_i,
  input  logic [rdct_pkg::CALIB_BITS-1:0]  ten_ms_i,
  output rdct_pkg::result_t                result_o
);
  import rdct_pkg::*;

  localparam logic [COUNTER_BITS-1:0] ResetCount = COUNTER_BITS'(RESET_COUNT);

  logic                    enable_q, enable_d;
  logic                    tie_q, tie_d;
  logic                    flag_q, flag_d;
  logic                    halted_q, halted_d;
  logic                    irq_q, irq_d;
  logic [COUNTER_BITS-1:0] reload_q, reload_d;
  logic [COUNTER_BITS-1:0] cur_q, cur_d;
  logic [DATA_BITS-1:0]    rdata;
  logic                    addr_err;
  reg_e                    reg_sel;

  assign reg_sel = reg_e'(item_i.address[3:2]);

  // Next state and read data for the item in execution.
  always_comb begin
    enable_d = enable_q;
    tie_d    = tie_q;
    flag_d   = flag_q;
    halted_d = halted_q;
    irq_d    = irq_q;
    reload_d = reload_q;
    cur_d    = cur_q;
    rdata    = '0;
    addr_err = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        // Count down while running; at zero reload and flag the wrap.
        if (enable_q && !halted_q) begin
          if (cur_q == '0) begin
            cur_d  = reload_q;
            flag_d = 1'b1;
            if (tie_q) begin
              irq_d = 1'b1;
            end
            if (reload_q == '0) begin
              halted_d = 1'b1;
            end
          end else begin
            cur_d = cur_q - COUNTER_BITS'(1);
          end
        end
      end
      KIND_EXC_RETURN: begin
        if (item_i.exception_number == TICK_EXCEPTION) begin
          irq_d = 1'b0;
        end
      end
      default: begin
        // Bus access: only the first four words are mapped.
        if (item_i.address[ADDR_BITS-1:4] != '0) begin
          addr_err = 1'b1;
        end else if (item_i.kind == KIND_READ) begin
          case (reg_sel)
            REG_CTRL: begin
              // Flag at bit 16, clock source reads one at bit 2.
              rdata  = {15'd0, flag_q, 13'd0, 1'b1, tie_q, enable_q};
              flag_d = 1'b0;
            end
            REG_RELOAD:  rdata = DATA_BITS'(reload_q);
            REG_CURRENT: rdata = DATA_BITS'(cur_q);
            REG_CALIB:   rdata = {1'b1, 7'd0, ten_ms_i};
            default:     rdata = '0;
          endcase
        end else begin
          case (reg_sel)
            REG_CTRL: begin
              enable_d = item_i.write_data[0];
              tie_d    = item_i.write_data[1];
              // A rising enable restarts a halted or expired counter.
              if (!enable_q && item_i.write_data[0]) begin
                halted_d = 1'b0;
                if (cur_q == '0) begin
                  cur_d = reload_q;
                end
              end
            end
            REG_RELOAD: reload_d = item_i.write_data[COUNTER_BITS-1:0];
            REG_CURRENT: begin
              flag_d   = 1'b0;
              halted_d = 1'b0;
              cur_d    = enable_q ? reload_q : '0;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  // State registers advance only when an item executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      tie_q    <= 1'b0;
      flag_q   <= 1'b0;
      halted_q <= 1'b0;
      irq_q    <= 1'b0;
      reload_q <= ResetCount;
      cur_q    <= ResetCount;
    end else if (exec_i) begin
      enable_q <= enable_d;
      tie_q    <= tie_d;
      flag_q   <= flag_d;
      halted_q <= halted_d;
      irq_q    <= irq_d;
      reload_q <= reload_d;
      cur_q    <= cur_d;
    end
  end

  assign result_o.read_data     = rdata;
  assign result_o.irq           = irq_d;
  assign result_o.address_error = addr_err;

`ifndef SYNTHESIS
  // The counter only moves when an item executes.
  a_cur_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_i |=> $stable(cur_q))
    else $error("counter changed without an item");

  // The timer halts only after expiring with a zero reload value.
  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> $past(reload_q) == '0)
    else $error("halted with nonzero reload");

  // The interrupt is raised only by a tick with tick interrupts enabled.
  a_irq_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(exec_i && item_i.kind == KIND_TICK && tie_q))
    else $error("interrupt raised without an enabled tick");

  // Setting the count flag comes with a reload of the counter.
  a_flag_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> cur_q == reload_q)
    else $error("count flag set without reload");
`endif

endmodule

### rtl/core/reload_down_counter_timer.sv
// Top level of the reload down-counter timer: input register, core, result register.
// Depends on rdct_pkg and rdct_core.
//
//   Channel   Direction  Transfer when                     Contents
//   s_axis    in         s_axis_tvalid & s_axis_tready     one item (tick, read, write, return)
//   m_axis    out        m_axis_tvalid & m_axis_tready     one result per item
//   cfg       in         cfg_valid_i & cfg_ready_o         calibration ten-ms count
//
// An item is held in the input register, executed when the result register can load,
// and its result is then registered in the result register; a stall on m_axis can
// delay execution. One item per cycle is sustained while m_axis is not stalled.
// The single state update of the core between the two registers sets that rate.
// Reset clears the timer to disabled with reload and current at 0xaaaa (masked).
// A stall on m_axis holds the result register and, once the input register is
// full, deasserts s_axis_tready in the same cycle.
module reload_down_counter_timer #(
  parameter int unsigned COUNTER_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // address [7:0], write_data [39:8], exception_number [45:40], zeros above
  input  logic [47:0] s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // read_data [31:0], irq [32], zeros above
  output logic [39:0] m_axis_tdata,
  // address_error [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);
  import rdct_pkg::*;

  logic                  in_valid_q;
  item_t                 in_item_q;
  logic                  out_valid_q;
  result_t               out_res_q;
  result_t               res;
  logic [CALIB_BITS-1:0] ten_ms_q;
  logic                  advance;
  logic                  exec;

  // The result register can load when empty or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign exec          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.kind             <= kind_e'(s_axis_tuser);
      in_item_q.address          <= s_axis_tdata[7:0];
      in_item_q.write_data       <= s_axis_tdata[39:8];
      in_item_q.exception_number <= s_axis_tdata[45:40];
    end
  end

  // Calibration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_ms_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ten_ms_q <= cfg_data_i;
    end
  end

  rdct_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .item_i  (in_item_q),
    .ten_ms_i(ten_ms_q),
    .result_o(res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.irq, out_res_q.read_data};
  assign m_axis_tuser  = out_res_q.address_error;

endmodule

### dv/reload_down_counter_timer_tb.sv
// Self-checking testbench for the reload down-counter timer.
// Drives items and calibration writes, predicts each result in-house, and checks it.
// Depends on rdct_pkg and reload_down_counter_timer.
module reload_down_counter_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdct_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned LATENCY       = 2;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned LONG_HOLD     = 120;
  localparam logic [31:0] CTRL_CLKSRC   = 32'h0000_0004;
  localparam logic [31:0] CALIB_NOREF   = 32'h8000_0000;
  localparam logic [23:0] CNT_MASK      = 24'hff_ffff;

  // One directed stimulus row; typed rows carry their own expected result.
  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] cfg_data_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;

  // Timer state as the predictor sees it.
  logic        tmr_enable;
  logic        tmr_tickint;
  logic        tmr_flag;
  logic        tmr_halted;
  logic        tmr_irq;
  logic [23:0] tmr_reload;
  logic [23:0] tmr_current;
  logic [23:0] cal_ten_ms;

  result_t     pending_results[$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_kind[4] = '{0, 0, 0, 0};
  int unsigned n_expiries = 0;
  int unsigned n_addr_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_requests = 0;

  reload_down_counter_timer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Run limit: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("reload_down_counter_timer test failed");
      $finish;
    end
  end

  // Timer behavior for one item: updates the predicted state, returns the result.
  function automatic result_t timer_step(input item_t it);
    result_t r;
    reg_e    idx;
    logic    was_enabled;
    r = '0;
    idx = reg_e'(it.address[3:2]);
    case (it.kind)
      KIND_TICK: begin
        if (tmr_enable && !tmr_halted) begin
          if (tmr_current == 24'd0) begin
            tmr_current = tmr_reload;
            tmr_flag = 1'b1;
            n_expiries++;
            if (tmr_tickint) tmr_irq = 1'b1;
            if (tmr_reload == 24'd0) tmr_halted = 1'b1;
          end else begin
            tmr_current = (tmr_current - 24'd1) & CNT_MASK;
          end
        end
      end
      KIND_EXC_RETURN: begin
        if (it.exception_number == TICK_EXCEPTION) tmr_irq = 1'b0;
      end
      default: begin
        if (it.address >= 8'd16) begin
          r.address_error = 1'b1;
        end else if (it.kind == KIND_READ) begin
          case (idx)
            REG_CTRL: begin
              r.read_data = CTRL_CLKSRC | {15'd0, tmr_flag, 14'd0, tmr_tickint, tmr_enable};
              tmr_flag = 1'b0;
            end
            REG_RELOAD:  r.read_data = {8'd0, tmr_reload};
            REG_CURRENT: r.read_data = {8'd0, tmr_current};
            default:     r.read_data = CALIB_NOREF | {8'd0, cal_ten_ms};
          endcase
        end else begin
          case (idx)
            REG_CTRL: begin
              was_enabled = tmr_enable;
              tmr_enable = it.write_data[0];
              tmr_tickint = it.write_data[1];
              if (!was_enabled && tmr_enable) begin
                tmr_halted = 1'b0;
                if (tmr_current == 24'd0) tmr_current = tmr_reload;
              end
            end
            REG_RELOAD: tmr_reload = it.write_data[23:0];
            REG_CURRENT: begin
              tmr_flag = 1'b0;
              tmr_halted = 1'b0;
              tmr_current = tmr_enable ? tmr_reload : 24'd0;
            end
            default: ;
          endcase
        end
      end
    endcase
    r.irq = tmr_irq;
    return r;
  endfunction

  // Random item, biased toward valid registers, short reload periods and enabling.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) it.kind = KIND_TICK;
    else if (pick < 70) it.kind = KIND_READ;
    else if (pick < 90) it.kind = KIND_WRITE;
    else it.kind = KIND_EXC_RETURN;
    it.address = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    it.write_data = $urandom();
    if (it.kind == KIND_WRITE && reg_e'(it.address[3:2]) == REG_RELOAD &&
        $urandom_range(3) != 0) begin
      it.write_data[23:0] = 24'($urandom_range(12));
    end
    if (it.kind == KIND_WRITE && reg_e'(it.address[3:2]) == REG_CTRL) begin
      it.write_data[0] = ($urandom_range(9) != 0);
    end
    it.exception_number = $urandom_range(1) ? TICK_EXCEPTION : 6'($urandom_range(63));
    return it;
  endfunction

  function automatic dir_row_t drow(input kind_e k, input logic [7:0] a, input logic [31:0] d,
                                    input logic [5:0] e, input bit typed,
                                    input logic [31:0] rd, input logic ir, input logic er);
    dir_row_t row;
    row.it = '{kind: k, address: a, write_data: d, exception_number: e};
    row.typed = typed;
    row.res = '{read_data: rd, irq: ir, address_error: er};
    return row;
  endfunction

  // Offers one item, waits for its transfer, records the expected result, then idles at random.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t predicted;
    s_axis_tdata  <= {2'b00, it.exception_number, it.write_data, it.address};
    s_axis_tuser  <= it.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = timer_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
    n_kind[it.kind]++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Calibration write; only issued while the timer has nothing in flight.
  task automatic write_calibration(input logic [23:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cal_ten_ms = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering items until every expected result has been seen.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                  input bit with_pressure);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      if (with_pressure && i == 60) hold_requests++;
      if (with_pressure && i == 180) wait_all_results();
      send_item(random_item(), 1'b0, '0);
    end
    wait_all_results();
  endtask

  // Result side: random backpressure, a long hold-off on request, and the checks.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    result_t     want;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (m_axis_tuser) n_addr_errors++;
          if (m_axis_tdata[31:0] !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, m_axis_tdata[31:0]);
            n_errors++;
          end
          if (m_axis_tdata[32] !== want.irq) begin
            $error("irq: expected %b, actual %b", want.irq, m_axis_tdata[32]);
            n_errors++;
          end
          if (m_axis_tuser !== want.address_error) begin
            $error("address_error: expected %b, actual %b", want.address_error, m_axis_tuser);
            n_errors++;
          end
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus sequence: reset, calibration writes, directed rows, then three random phases.
  initial begin
    dir_row_t dir_rows[$];
    rst_ni        <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TICK;
    s_axis_tvalid <= 1'b0;
    cfg_data_i    <= '0;
    cfg_valid_i   <= 1'b0;
    tmr_enable  = 1'b0;
    tmr_tickint = 1'b0;
    tmr_flag    = 1'b0;
    tmr_halted  = 1'b0;
    tmr_irq     = 1'b0;
    tmr_reload  = RESET_COUNT[23:0];
    tmr_current = RESET_COUNT[23:0];
    cal_ten_ms  = 24'd0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_calibration(24'hff_ffff);

    // Reset values, bad addresses, then the enable, expiry, halt and return cases.
    dir_rows.push_back(drow(KIND_READ, 8'd0, '0, '0, 1'b1, 32'h0000_0004, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd4, '0, '0, 1'b1, 32'h0000_aaaa, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd8, '0, '0, 1'b1, 32'h0000_aaaa, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd12, '0, '0, 1'b1, 32'h80ff_ffff, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd255, '0, '0, 1'b1, 32'h0, 1'b0, 1'b1));
    dir_rows.push_back(drow(KIND_WRITE, 8'd16, '1, '0, 1'b1, 32'h0, 1'b0, 1'b1));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b1, 32'h0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd4, '1, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd8, '1, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd11, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd0, '1, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd4, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd8, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_READ, 8'd1, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_EXC_RETURN, 8'd255, '1, 6'd63, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_EXC_RETURN, 8'd0, '0, TICK_EXCEPTION, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd4, 32'hff00_0001, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd12, '1, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_WRITE, 8'd8, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
    dir_rows.push_back(drow(KIND_TICK, 8'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0));

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    wait_all_results();

    write_calibration(24'h00_0000);
    run_random_phase(38, 67, 1'b0);
    write_calibration(24'($urandom()));
    run_random_phase(67, 38, 1'b0);
    write_calibration(24'h80_0001);
    run_random_phase(0, 0, 1'b1);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
    end
    $display("Covered %0d ticks, %0d reads, %0d writes, %0d exception returns; %0d expiries.",
             n_kind[KIND_TICK], n_kind[KIND_READ], n_kind[KIND_WRITE],
             n_kind[KIND_EXC_RETURN], n_expiries);
    $display("Checked %0d results (%0d address errors) under three idle mixes and a long stall.",
             n_checked, n_addr_errors);
    if (n_errors == 0) begin
      $display("reload_down_counter_timer test passed");
    end else begin
      $display("reload_down_counter_timer test failed");
    end
    $finish;
  end

endmodule
